// ===== src/frame_deframer_checker_assert.svh =====
`ifndef FRAME_DEFRAMER_CHECKER_ASSERT_SVH
`define FRAME_DEFRAMER_CHECKER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define FDC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame deframer checker: assertion failed");

// Next-cycle implication, held off during reset.
`define FDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame deframer checker: assertion failed");

`endif

// ===== src/fdc_pkg.sv =====
package fdc_pkg;

  localparam int HEADER_BYTES = 28;
  localparam int CRC_SPAN     = 24;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_BODY   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TRUNC       = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_BAD_CRC     = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd5;

  localparam logic [1:0] REG_MAGIC       = 2'd0;
  localparam logic [1:0] REG_VERSION     = 2'd1;
  localparam logic [1:0] REG_MAX_BODY    = 2'd2;

  localparam logic [31:0] MAGIC_RESET    = 32'd0;
  localparam logic [15:0] VERSION_RESET  = 16'd1;
  localparam logic [31:0] MAX_BODY_RESET = 32'd65508;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic        frame_end;
    logic [15:0] message_type;
    logic [31:0] flag_bits;
    logic [31:0] body_len;
    logic [63:0] req_id;
    logic [2:0]  status;
    logic        run_last;
  } res_t;

  // One queued action: the first result, and whether a truncation error follows it.
  typedef struct packed {
    logic two;
    res_t res;
  } act_t;

  typedef struct packed {
    logic out_valid;
    logic pend;
  } back_stat_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/fdc_front.sv =====
module fdc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              end_of_data,
  output logic              act_valid,
  output fdc_pkg::act_t     act
);
  import fdc_pkg::*;

  localparam int POS_W = $clog2(HEADER_BYTES);
  localparam int HDR_W = (HEADER_BYTES - 1) * 8;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_CRC  = POS_W'(CRC_SPAN);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_DROP   = 2'd2;

  logic [1:0]       phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [31:0]      crc, crc_next;
  logic [31:0]      remaining, remaining_next;
  logic [HDR_W-1:0] hdr;

  logic [31:0] magic_value;
  logic [15:0] expected_version;
  logic [31:0] max_body_length;

  logic [31:0] crc_rx;
  logic [31:0] len;
  logic [31:0] rem_dec;
  logic [2:0]  hdr_status;

  assign cfg_ready = 1'b1;

  // last CRC byte comes straight off the input
  assign crc_rx  = {in_byte, hdr[HDR_W-1 -: 24]};
  assign len     = hdr[127:96];
  assign rem_dec = (remaining == 32'd0) ? 32'd0 : remaining - 32'd1;

  always_comb begin
    priority if (hdr[31:0] != magic_value)      hdr_status = ST_BAD_MAGIC;
    else if (hdr[47:32] != expected_version)    hdr_status = ST_BAD_VERSION;
    else if (crc_rx != ~crc)                    hdr_status = ST_BAD_CRC;
    else if (len > max_body_length)             hdr_status = ST_TOO_LARGE;
    else                                        hdr_status = ST_OK;
  end

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    crc_next       = crc;
    remaining_next = remaining;
    act_valid      = 1'b0;
    act            = '0;
    unique case (phase)
      PH_HEADER: begin
        if (pos < POS_CRC) begin
          crc_next = crc32_byte(crc, in_byte);
        end
        if (pos < POS_LAST) begin
          pos_next = pos + POS_W'(1);
          if (end_of_data) begin
            act_valid      = 1'b1;
            act.res.kind   = KIND_ERROR;
            act.res.status = ST_TRUNC;
            act.res.run_last = 1'b1;
            pos_next       = '0;
            crc_next       = '1;
          end
        end else begin
          act_valid = 1'b1;
          pos_next  = '0;
          crc_next  = '1;
          if (hdr_status != ST_OK) begin
            act.res.kind     = KIND_ERROR;
            act.res.status   = hdr_status;
            act.res.run_last = 1'b1;
            phase_next       = end_of_data ? PH_HEADER : PH_DROP;
          end else begin
            act.res.kind         = KIND_HEADER;
            act.res.message_type = hdr[63:48];
            act.res.flag_bits    = hdr[95:64];
            act.res.body_len     = len;
            act.res.req_id       = hdr[191:128];
            act.res.frame_end    = (len == 32'd0);
            act.two              = (len != 32'd0) && end_of_data;
            act.res.run_last     = !act.two;
            remaining_next       = len;
            phase_next           = ((len != 32'd0) && !end_of_data) ? PH_BODY : PH_HEADER;
          end
        end
      end
      PH_BODY: begin
        act_valid         = 1'b1;
        act.res.kind      = KIND_BODY;
        act.res.body_byte = in_byte;
        act.res.frame_end = (rem_dec == 32'd0);
        act.two           = (rem_dec != 32'd0) && end_of_data;
        act.res.run_last  = !act.two;
        remaining_next    = rem_dec;
        if ((rem_dec == 32'd0) || end_of_data) begin
          phase_next     = PH_HEADER;
          remaining_next = '0;
        end
      end
      default: begin
        // drop through the end-of-data mark; unused code behaves the same
        if (end_of_data) begin
          phase_next = PH_HEADER;
        end
      end
    endcase
    if (!accept) begin
      act_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      pos       <= '0;
      crc       <= '1;
      remaining <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      pos       <= pos_next;
      crc       <= crc_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase == PH_HEADER) && (pos < POS_LAST)) begin
      hdr[{pos, 3'b000} +: 8] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value      <= MAGIC_RESET;
      expected_version <= VERSION_RESET;
      max_body_length  <= MAX_BODY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAGIC:    magic_value      <= cfg_data;
        REG_VERSION:  expected_version <= cfg_data[15:0];
        REG_MAX_BODY: max_body_length  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/fdc_queue.sv =====
module fdc_queue #(
  parameter int DEPTH = fdc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  fdc_pkg::act_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          avail,
  output fdc_pkg::act_t rd_data
);
  import fdc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  act_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign avail   = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

endmodule

// ===== src/fdc_back.sv =====
module fdc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  fdc_pkg::act_t       head,
  output logic                head_take,
  input  logic                pop,
  output logic                empty,
  output fdc_pkg::res_t       res,
  output fdc_pkg::back_stat_t stat
);
  import fdc_pkg::*;

  logic out_valid;
  logic pend;
  logic load;
  res_t trunc_word;

  always_comb begin
    trunc_word          = '0;
    trunc_word.kind     = KIND_ERROR;
    trunc_word.status   = ST_TRUNC;
    trunc_word.run_last = 1'b1;
  end

  // output register frees when empty or being popped
  assign load      = !out_valid || pop;
  assign head_take = load && !pend && head_valid;
  assign empty     = !out_valid;
  assign stat      = '{out_valid: out_valid, pend: pend};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else begin
        out_valid <= head_valid;
        pend      <= head_valid && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        res <= trunc_word;
      end else if (head_valid) begin
        res <= head.res;
      end
    end
  end

endmodule

// ===== src/frame_deframer_checker.sv =====
// With the path empty, a byte's first result enters the action queue, then the output
// register, which drives the ports.
// Throughput: one byte per cycle unless the queue is full; a byte yielding a header or body
// word plus a truncation error sends word, then error, through the single output stage.
// Reset (synchronous, active high): registers return to their defaults, the parser to
// the header phase, and the action queue and output stage empty; no clearing pass.
`include "frame_deframer_checker_assert.svh"

module frame_deframer_checker #(
  parameter int QUEUE_DEPTH = fdc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  body_byte,
  output logic        frame_end,
  output logic [15:0] message_type,
  output logic [31:0] flag_bits,
  output logic [31:0] body_len,
  output logic [63:0] req_id,
  output logic [2:0]  status,
  output logic        run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fdc_pkg::*;

  logic       accept;
  logic       act_valid;
  act_t       act;
  logic       q_avail;
  act_t       q_head;
  logic       q_take;
  res_t       res;
  back_stat_t bstat;

  assign accept = push && !full;

  fdc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_data (end_of_data),
    .act_valid   (act_valid),
    .act         (act)
  );

  fdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (act_valid),
    .wr_data (act),
    .full    (full),
    .rd_en   (q_take),
    .avail   (q_avail),
    .rd_data (q_head)
  );

  fdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_avail),
    .head       (q_head),
    .head_take  (q_take),
    .pop        (pop),
    .empty      (empty),
    .res        (res),
    .stat       (bstat)
  );

  assign kind         = res.kind;
  assign body_byte    = res.body_byte;
  assign frame_end    = res.frame_end;
  assign message_type = res.message_type;
  assign flag_bits    = res.flag_bits;
  assign body_len     = res.body_len;
  assign req_id       = res.req_id;
  assign status       = res.status;
  assign run_last     = res.run_last;

  `FDC_ASSERT_IMP(a_pend_has_word, clk, rst, bstat.pend, bstat.out_valid)
  `FDC_ASSERT_IMP(a_not_last_pend, clk, rst, !empty && !run_last, bstat.pend)
  `FDC_ASSERT_IMP(a_end_not_error, clk, rst, !empty && frame_end, kind != KIND_ERROR)
  `FDC_ASSERT_NEXT(a_trunc_follows, clk, rst, !empty && pop && bstat.pend, !empty && kind == KIND_ERROR && status == ST_TRUNC && run_last)

endmodule
